@@ hdl/tcw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants and types for the trapezoid coverage weight pipeline.
// ----------------------------------------------------------------------------
package tcw_pkg;

   // fixed widths of the port fields
   localparam int FIELD_BITS    = 24;
   localparam int WEIGHT_BITS   = 40;

   // parameter defaults
   localparam int POS_BITS_DEF  = 24;
   localparam int FRAC_BITS_DEF = 16;

   // control that travels with each beat down the pipeline
   typedef struct packed {
      logic valid;   // stage holds a beat
      logic unit;    // empty fragment or zero length: weight is one
   } tcw_ctl_type;

endpackage

@@ hdl/trapezoid_coverage_weight.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trapezoid_coverage_weight
// Inverse coverage weight of a fragment under the trapezoid coverage model,
// unsigned fixed point with FRAC_BITS fraction bits, truncated.
//
//   port group   direction  handshake            payload
//   req_*        in         req_valid/req_stall  fragment_start, fragment_end,
//                                                transcript_len
//   rsp_*        out        rsp_valid/rsp_stall  weight_q16
//
// One beat accepted per cycle while no held result stalls the pipeline.
// The stages are the four area stages, one divider stage per quotient bit,
// and the output register. Reset is synchronous and empties every stage.
// A held result stalls the whole pipeline in place; req_stall follows it.
// ----------------------------------------------------------------------------
module trapezoid_coverage_weight import tcw_pkg::*; #(
   parameter int POS_BITS  = POS_BITS_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [FIELD_BITS-1:0]   req_fragment_start,
   input  logic [FIELD_BITS-1:0]   req_fragment_end,
   input  logic [FIELD_BITS-1:0]   req_transcript_len,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [WEIGHT_BITS-1:0]  rsp_weight_q16
);

   localparam int AW = 2 * POS_BITS + 4;
   localparam int QB = POS_BITS - 1 + FRAC_BITS;

   logic                   adv;
   tcw_ctl_type            area_ctl, div_ctl;
   logic [AW-1:0]          num, den;
   logic [QB-1:0]          quo;
   logic                   rsp_valid_ff;
   logic [WEIGHT_BITS-1:0] weight_ff, weight_in;

   // the whole pipeline moves unless a result is held
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   tcw_area #(.POS_BITS(POS_BITS)) u_area (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_valid),
      .start    (POS_BITS'(req_fragment_start)),
      .stop     (POS_BITS'(req_fragment_end)),
      .len      (POS_BITS'(req_transcript_len)),
      .out_ctl  (area_ctl),
      .num      (num),
      .den      (den)
   );

   tcw_div #(.POS_BITS(POS_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_ctl  (area_ctl),
      .num     (num),
      .den     (den),
      .out_ctl (div_ctl),
      .quo     (quo)
   );

   // substitute one for degenerate beats
   assign weight_in = div_ctl.unit ? (WEIGHT_BITS'(1) << FRAC_BITS) : WEIGHT_BITS'(quo);

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= div_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         weight_ff <= weight_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_weight_q16 = weight_ff;

endmodule

@@ hdl/tcw_area.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_area
// Four register stages: fragment length and ramp width, clamping to the
// three regions, the products, then the area sum. Emits the numerator
// 4*W2*f and denominator max(8*area, 8f) for the divider.
// ----------------------------------------------------------------------------
module tcw_area import tcw_pkg::*; #(
   parameter int POS_BITS = POS_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  logic                      in_valid,
   input  logic [POS_BITS-1:0]       start,
   input  logic [POS_BITS-1:0]       stop,
   input  logic [POS_BITS-1:0]       len,
   output tcw_ctl_type               out_ctl,
   output logic [2*POS_BITS+3:0]     num,
   output logic [2*POS_BITS+3:0]     den
);

   localparam int HW = POS_BITS + 2;     // half-unit positions
   localparam int AW = 2 * HW;           // area in eighths

   function automatic logic [HW-1:0] clamp(input logic [HW-1:0] x,
                                           input logic [HW-1:0] lo,
                                           input logic [HW-1:0] hi);
      logic [HW-1:0] y;
      if (x < lo) begin
         y = lo;
      end else if (x > hi) begin
         y = hi;
      end else begin
         y = x;
      end
      return y;
   endfunction

   // ---- stage 1: length, ramp width, half-unit positions
   logic [POS_BITS:0]   fdiff;
   logic [POS_BITS:0]   f2;
   tcw_ctl_type         c1_in, c1_ff;
   logic [POS_BITS-1:0] f1_in, f1_ff;
   logic [HW-1:0]       w2_1_in, w2_1_ff, full2_in, full2_ff, s2_in, s2_ff, e2_in, e2_ff;

   always_comb begin
      fdiff       = {1'b0, stop} - {1'b0, start};
      f1_in       = fdiff[POS_BITS-1:0];
      f2          = {f1_in, 1'b0};
      c1_in.valid = in_valid;
      c1_in.unit  = (stop <= start) || (len == '0);
      w2_1_in     = (f2 < {1'b0, len}) ? HW'(f2) : HW'(len);
      full2_in    = HW'({len, 1'b0});
      s2_in       = HW'({start, 1'b0});
      e2_in       = HW'({stop, 1'b0});
   end

   // ---- stage 2: clamp to left ramp, plateau and right ramp
   logic [HW-1:0] lw2, ls, le, ps, pe, rs, re;
   tcw_ctl_type   c2_ff;
   logic [POS_BITS-1:0] f2_ff;
   logic [HW-1:0] ld_in, ld_ff, lsum_in, lsum_ff, pd_in, pd_ff, w2_2_ff;
   logic [HW-1:0] rd_in, rd_ff, rsum_in, rsum_ff;

   always_comb begin
      lw2     = full2_ff - w2_1_ff;
      ls      = clamp(s2_ff, '0, w2_1_ff);
      le      = clamp(e2_ff, '0, w2_1_ff);
      ps      = clamp(s2_ff, w2_1_ff, lw2);
      pe      = clamp(e2_ff, w2_1_ff, lw2);
      rs      = clamp(s2_ff, lw2, full2_ff);
      re      = clamp(e2_ff, lw2, full2_ff);
      ld_in   = le - ls;
      lsum_in = ls + le;
      pd_in   = pe - ps;
      rd_in   = re - rs;
      rsum_in = {full2_ff[HW-2:0], 1'b0} - rs - re;
   end

   // ---- stage 3: products
   tcw_ctl_type         c3_ff;
   logic [POS_BITS-1:0] f3_ff;
   logic [AW-1:0]       ml_in, ml_ff, mp_in, mp_ff, mr_in, mr_ff, mn_in, mn_ff;

   always_comb begin
      ml_in = ld_ff * lsum_ff;
      mp_in = pd_ff * w2_2_ff;
      mr_in = rd_ff * rsum_ff;
      mn_in = w2_2_ff * AW'(f2_ff);
   end

   // ---- stage 4: area sum and denominator floor
   logic [AW-1:0] area8, f8, num_in, num_ff, den_in, den_ff;
   tcw_ctl_type   c4_ff;

   always_comb begin
      area8  = ml_ff + {mp_ff[AW-2:0], 1'b0} + mr_ff;
      f8     = AW'({f3_ff, 3'b000});
      den_in = (area8 > f8) ? area8 : f8;
      num_in = {mn_ff[AW-3:0], 2'b00};
   end

   // advance control
   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff.valid <= 1'b0;
         c2_ff.valid <= 1'b0;
         c3_ff.valid <= 1'b0;
         c4_ff.valid <= 1'b0;
      end else if (adv) begin
         c1_ff <= c1_in;
         c2_ff <= c1_ff;
         c3_ff <= c2_ff;
         c4_ff <= c3_ff;
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (adv) begin
         f1_ff    <= f1_in;
         w2_1_ff  <= w2_1_in;
         full2_ff <= full2_in;
         s2_ff    <= s2_in;
         e2_ff    <= e2_in;
         f2_ff    <= f1_ff;
         w2_2_ff  <= w2_1_ff;
         ld_ff    <= ld_in;
         lsum_ff  <= lsum_in;
         pd_ff    <= pd_in;
         rd_ff    <= rd_in;
         rsum_ff  <= rsum_in;
         f3_ff    <= f2_ff;
         ml_ff    <= ml_in;
         mp_ff    <= mp_in;
         mr_ff    <= mr_in;
         mn_ff    <= mn_in;
         num_ff   <= num_in;
         den_ff   <= den_in;
      end
   end

   assign out_ctl = c4_ff;
   assign num     = num_ff;
   assign den     = den_ff;

endmodule

@@ hdl/tcw_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_div
// Pipelined restoring divider: one quotient bit per stage, giving
// floor(num * 2^FRAC_BITS / den) in POS_BITS-1+FRAC_BITS bits.
// ----------------------------------------------------------------------------
module tcw_div import tcw_pkg::*; #(
   parameter int POS_BITS  = POS_BITS_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  tcw_ctl_type                       in_ctl,
   input  logic [2*POS_BITS+3:0]             num,
   input  logic [2*POS_BITS+3:0]             den,
   output tcw_ctl_type                       out_ctl,
   output logic [POS_BITS+FRAC_BITS-2:0]     quo
);

   localparam int AW = 2 * POS_BITS + 4;
   localparam int QB = POS_BITS - 1 + FRAC_BITS;

   logic [AW-1:0]  r_ff   [QB-1];
   logic [AW-1:0]  den_ff [QB-1];
   logic [QB-1:0]  lo_ff  [QB-1];
   logic [QB-1:0]  q_ff   [QB];
   tcw_ctl_type    ctl_ff [QB];

   for (genvar k = 0; k < QB; k++) begin : g_stage
      logic [AW-1:0] r_src, den_src;
      logic [QB-1:0] lo_src, q_src;
      tcw_ctl_type   c_src;
      logic [AW:0]   t;
      logic [AW:0]   diff;
      logic          take;

      // pick up the partial remainder from the stage before
      if (k == 0) begin : g_head
         assign r_src   = num >> (POS_BITS - 1);
         assign den_src = den;
         assign lo_src  = {num[POS_BITS-2:0], {FRAC_BITS{1'b0}}};
         assign q_src   = '0;
         assign c_src   = in_ctl;
      end else begin : g_body
         assign r_src   = r_ff[k-1];
         assign den_src = den_ff[k-1];
         assign lo_src  = lo_ff[k-1];
         assign q_src   = q_ff[k-1];
         assign c_src   = ctl_ff[k-1];
      end

      // shift in the next dividend bit, subtract where it fits
      always_comb begin
         t    = {r_src, lo_src[QB-1]};
         diff = t - {1'b0, den_src};
         take = (t >= {1'b0, den_src});
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k].valid <= 1'b0;
         end else if (adv) begin
            ctl_ff[k] <= c_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            q_ff[k] <= {q_src[QB-2:0], take};
         end
      end

      if (k < QB - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (adv) begin
               r_ff[k]   <= take ? diff[AW-1:0] : t[AW-1:0];
               den_ff[k] <= den_src;
               lo_ff[k]  <= {lo_src[QB-2:0], 1'b0};
            end
         end
      end
   end

   assign out_ctl = ctl_ff[QB-1];
   assign quo     = q_ff[QB-1];

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks trapezoid_coverage_weight beat by beat against an exact predictor
// of the inverse coverage weight. Directed extremes come first, then random
// fragments under three idling phases on the request and response sides.
// ----------------------------------------------------------------------------
module testbench;
   import tcw_pkg::*;

   localparam int  FRAC = FRAC_BITS_DEF;
   localparam int  LAT  = POS_BITS_DEF + FRAC_BITS_DEF + 4;

   typedef struct packed {
      logic [FIELD_BITS-1:0] first_pos;
      logic [FIELD_BITS-1:0] last_pos;
      logic [FIELD_BITS-1:0] tx_len;
   } fragment_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [FIELD_BITS-1:0]  req_fragment_start = '0;
   logic [FIELD_BITS-1:0]  req_fragment_end = '0;
   logic [FIELD_BITS-1:0]  req_transcript_len = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [WEIGHT_BITS-1:0] rsp_weight_q16;

   fragment_type           pending_frags[$];
   logic [WEIGHT_BITS-1:0] expected_weights[$];
   int                     mismatches = 0;
   int                     send_idle_pct = 34;
   int                     recv_idle_pct = 63;

   trapezoid_coverage_weight dut (.*);

   always #4 clock = ~clock;

   function automatic longint unsigned clampu(longint unsigned x, longint unsigned lo,
                                              longint unsigned hi);
      if (x < lo) return lo;
      if (x > hi) return hi;
      return x;
   endfunction

   // exact weight in half-base units, long division to FRAC fraction bits
   function automatic logic [WEIGHT_BITS-1:0] coverage_weight(fragment_type fr);
      longint unsigned st, en, ln, f, w2, full2, lw2, s2, e2, s, e, a8, den, num, q, r;
      st = fr.first_pos; en = fr.last_pos; ln = fr.tx_len;
      if (en <= st || ln == 0) return WEIGHT_BITS'(64'd1 << FRAC);
      f = en - st;
      w2 = (2 * f < ln) ? 2 * f : ln;
      full2 = 2 * ln;
      lw2 = full2 - w2;
      s2 = 2 * st;
      e2 = 2 * en;
      a8 = 0;
      s = clampu(s2, 0, w2); e = clampu(e2, 0, w2);
      if (s < e) a8 += (e - s) * (s + e);
      s = clampu(s2, w2, lw2); e = clampu(e2, w2, lw2);
      if (s < e) a8 += 2 * (e - s) * w2;
      s = clampu(s2, lw2, full2); e = clampu(e2, lw2, full2);
      if (s < e) a8 += (e - s) * (2 * full2 - s - e);
      den = (a8 > 8 * f) ? a8 : 8 * f;
      num = 4 * w2 * f;
      q = num / den;
      r = num % den;
      for (int i = 0; i < FRAC; i++) begin
         q = q << 1;
         r = r << 1;
         if (r >= den) begin
            r -= den;
            q |= 1;
         end
      end
      return q[WEIGHT_BITS-1:0];
   endfunction

   // drive request beats; hold payload while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_frags.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            fragment_type fr;
            fr = pending_frags.pop_front();
            req_valid <= 1'b1;
            req_fragment_start <= fr.first_pos;
            req_fragment_end <= fr.last_pos;
            req_transcript_len <= fr.tx_len;
            expected_weights = {expected_weights, coverage_weight(fr)};
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // randomise response back-pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // compare accepted response beats with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_weights.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected beat: weight %h", rsp_weight_q16);
         end else begin
            logic [WEIGHT_BITS-1:0] exp_w;
            exp_w = expected_weights.pop_front();
            if (exp_w !== rsp_weight_q16) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("weight mismatch: expected %h actual %h", exp_w, rsp_weight_q16);
            end
         end
      end
   end

   function automatic fragment_type random_fragment();
      fragment_type fr;
      int           kind;
      kind = $urandom_range(9);
      fr.tx_len = (kind < 5) ? FIELD_BITS'($urandom_range(2000)) : FIELD_BITS'($urandom);
      if (kind == 9) begin
         fr.first_pos = FIELD_BITS'($urandom);
         fr.last_pos = FIELD_BITS'($urandom);
      end else begin
         fr.first_pos = (kind < 5) ? FIELD_BITS'($urandom_range(2200)) :
                        FIELD_BITS'($urandom_range(int'(fr.tx_len)));
         fr.last_pos = fr.first_pos + FIELD_BITS'(
                       (kind < 7) ? $urandom_range(600) : $urandom_range(int'(fr.tx_len)));
      end
      return fr;
   endfunction

   task automatic run_phase(int sidle, int ridle, int count);
      send_idle_pct = sidle;
      recv_idle_pct = ridle;
      for (int i = 0; i < count; i++) pending_frags = {pending_frags, random_fragment()};
      wait (pending_frags.size() == 0);
   endtask

   initial begin
      fragment_type d;
      logic [FIELD_BITS-1:0] mx;
      mx = '1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      // directed: empty, reversed, zero length, extremes, overhang, no overlap
      d = '{0, 0, 0};           pending_frags = {pending_frags, d};
      d = '{5, 5, 100};         pending_frags = {pending_frags, d};
      d = '{9, 3, 100};         pending_frags = {pending_frags, d};
      d = '{0, 10, 0};          pending_frags = {pending_frags, d};
      d = '{0, mx, mx};         pending_frags = {pending_frags, d};
      d = '{0, mx, 1};          pending_frags = {pending_frags, d};
      d = '{mx - 1, mx, mx};    pending_frags = {pending_frags, d};
      d = '{0, 1, mx};          pending_frags = {pending_frags, d};
      d = '{0, 1, 1};           pending_frags = {pending_frags, d};
      d = '{90, 120, 100};      pending_frags = {pending_frags, d};
      d = '{200, 300, 100};     pending_frags = {pending_frags, d};
      d = '{0, 100, 100};       pending_frags = {pending_frags, d};
      d = '{40, 60, 1000};      pending_frags = {pending_frags, d};
      d = '{0, 30, 1000};       pending_frags = {pending_frags, d};
      d = '{970, 1000, 1000};   pending_frags = {pending_frags, d};
      d = '{3, 8, 7};           pending_frags = {pending_frags, d};
      d = '{mx, mx, mx};        pending_frags = {pending_frags, d};
      d = '{24'h555555, 24'haaaaaa, 24'hffffff}; pending_frags = {pending_frags, d};
      d = '{0, mx, 0};          pending_frags = {pending_frags, d};
      run_phase(34, 63, 520);
      run_phase(63, 34, 520);
      run_phase(0, 0, 510);
      wait (!req_valid && expected_weights.size() == 0);
      repeat (LAT + 10) @(posedge clock);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // run limit
   initial begin
      #4000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
